FILE: rtl/lts_pkg.sv
`default_nettype none
package lts_pkg;

    // Widest index and count over the supported range of system orders.
    localparam int IDX_MAX_W = 6;
    localparam int CNT_MAX_W = 7;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS = 1'd1;

    // Input item kinds.
    localparam logic [1:0] KIND_L    = 2'd0;
    localparam logic [1:0] KIND_U    = 2'd1;
    localparam logic [1:0] KIND_PERM = 2'd2;
    localparam logic [1:0] KIND_RHS  = 2'd3;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PRM_WRITE,
        OP_ACC_INIT,
        OP_MUL,
        OP_ACC_SUB,
        OP_DIV_START,
        OP_VEC_WRITE,
        OP_CLEAR,
        OP_SCATTER,
        OP_OUT
    } t_op;

    // Source vector of a substitution pass.
    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_R
    } t_src;

    // Controller to datapath command.
    typedef struct packed {
        t_op                  op;
        logic [IDX_MAX_W-1:0] vaddr;
        logic [IDX_MAX_W-1:0] mrow;
        logic [IDX_MAX_W-1:0] mcol;
        logic                 mat_u;
        t_src                 src_sel;
        logic                 dst_b;
        logic                 out_b;
        logic                 rhs_by_perm;
        logic [CNT_MAX_W-1:0] n;
        logic                 out_last;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic solve_req;
        logic out_free;
        logic div_done;
    } t_stat;

endpackage
`default_nettype wire

FILE: rtl/lts_in_if.sv
`default_nettype none
interface lts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
    logic        last;

    modport source (output valid, kind, row, col, value, last, input ready);
    modport sink   (input valid, kind, row, col, value, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/lts_out_if.sv
`default_nettype none
interface lts_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] solution;
    logic        div_error;
    logic        end_of_run;

    modport source (output valid, index, solution, div_error, end_of_run, input ready);
    modport sink   (input valid, index, solution, div_error, end_of_run, output ready);
endinterface
`default_nettype wire

FILE: rtl/lts_div.sv
`default_nettype none
module lts_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quotient,
    output logic             o_div_zero
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [6:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [63:0] r_q, n_q;
    logic [31:0] r_d, n_d;
    logic        r_neg, n_neg;
    logic        r_dz, n_dz;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        q_hi;

    // One quotient bit per cycle, restoring, on magnitudes.
    always_comb begin
        rem_sh  = {r_rem, r_q[63]};
        rem_sub = rem_sh - {1'b0, r_d};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_q     = r_q;
        n_d     = r_d;
        n_neg   = r_neg;
        n_dz    = r_dz;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 7'd64;
            n_rem  = '0;
            n_q    = i_dividend[63] ? (64'd0 - i_dividend) : i_dividend;
            n_d    = i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            n_neg  = i_dividend[63] ^ i_divisor[31];
            n_dz   = (i_divisor == 32'd0);
        end else if (r_busy) begin
            if (!rem_sub[32]) begin
                n_rem = rem_sub[31:0];
                n_q   = {r_q[62:0], 1'b1};
            end else begin
                n_rem = rem_sh[31:0];
                n_q   = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= n_d;
        r_neg <= n_neg;
        r_dz  <= n_dz;
    end

    // Signed saturation of the quotient to 32 bits; zero on a zero divisor.
    always_comb begin
        q_hi = |r_q[63:31];
        if (r_dz) begin
            o_quotient = '0;
        end else if (r_neg) begin
            o_quotient = q_hi ? 32'h8000_0000 : (32'd0 - r_q[31:0]);
        end else begin
            o_quotient = q_hi ? 32'h7FFF_FFFF : r_q[31:0];
        end
    end

    assign o_done     = r_done;
    assign o_div_zero = r_dz;
endmodule
`default_nettype wire

FILE: rtl/lts_datapath.sv
`default_nettype none
module lts_datapath #(
    parameter int MAX_ORDER = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_kind,
    input  wire logic [3:0]    i_row,
    input  wire logic [3:0]    i_col,
    input  wire logic [31:0]   i_value,
    input  wire logic          i_last,
    input  wire lts_pkg::t_cmd i_cmd,
    output lts_pkg::t_stat     o_stat,
    lts_out_if.source          o_out
);
    import lts_pkg::*;

    localparam int IW        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int MAT_DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW        = (MAX_ORDER > 1) ? $clog2(MAT_DEPTH) : 1;

    logic [31:0] r_mem_l [MAT_DEPTH];
    logic [31:0] r_mem_u [MAT_DEPTH];
    logic [3:0]  r_mem_p [MAX_ORDER];
    logic [31:0] r_mem_r [MAX_ORDER];
    logic [31:0] r_mem_a [MAX_ORDER];
    logic [31:0] r_mem_b [MAX_ORDER];

    logic [31:0] r_rd_l, r_rd_u, r_rd_r, r_rd_a, r_rd_b;
    logic [3:0]  r_rd_p;
    logic [63:0] r_acc, r_prod;
    logic        r_err;
    logic        r_ovalid;
    logic [3:0]  r_oindex;
    logic [31:0] r_osol;
    logic        r_oerr, r_oend;

    logic          row_ok, col_ok, load;
    logic [AW-1:0] waddr_m, raddr_m;
    logic [IW-1:0] vaddr, raddr_r, paddr;
    logic          p_ok;
    logic [31:0]   src_val, dst_val, coef, q;
    logic signed [63:0] prod;
    logic [64:0]   diff;
    logic          div_done, div_zero;
    logic          we_a, we_b;
    logic [IW-1:0] waddr_a;
    logic [31:0]   wdata_a, wdata_b;

    // Load decode: items with an index beyond the stores are dropped.
    assign row_ok  = 32'(i_row) < MAX_ORDER;
    assign col_ok  = 32'(i_col) < MAX_ORDER;
    assign load    = (i_cmd.op == OP_LOAD) && i_in_valid;
    assign waddr_m = AW'(32'(i_row) * MAX_ORDER + 32'(i_col));
    assign raddr_m = AW'(32'(i_cmd.mrow) * MAX_ORDER + 32'(i_cmd.mcol));
    assign vaddr   = i_cmd.vaddr[IW-1:0];
    assign paddr   = r_rd_p[IW-1:0];
    assign raddr_r = i_cmd.rhs_by_perm ? paddr : vaddr;
    assign p_ok    = {3'b000, r_rd_p} < i_cmd.n;

    // Factor, permutation and rhs stores.
    always_ff @(posedge i_clk) begin
        if (load && i_kind == KIND_L && row_ok && col_ok) begin
            r_mem_l[waddr_m] <= i_value;
        end
        if (load && i_kind == KIND_U && row_ok && col_ok) begin
            r_mem_u[waddr_m] <= i_value;
        end
        if (load && i_kind == KIND_PERM && row_ok) begin
            r_mem_p[i_row[IW-1:0]] <= i_col;
        end
        if (load && i_kind == KIND_RHS && row_ok) begin
            r_mem_r[i_row[IW-1:0]] <= i_value;
        end
        r_rd_l <= r_mem_l[raddr_m];
        r_rd_u <= r_mem_u[raddr_m];
        r_rd_p <= r_mem_p[vaddr];
        r_rd_r <= r_mem_r[raddr_r];
    end

    // Operand selection from registered read data.
    always_comb begin
        case (i_cmd.src_sel)
            SRC_A:   src_val = r_rd_a;
            SRC_B:   src_val = r_rd_b;
            SRC_R:   src_val = r_rd_r;
            default: src_val = r_rd_r;
        endcase
        dst_val = i_cmd.dst_b ? r_rd_b : r_rd_a;
        coef    = i_cmd.mat_u ? r_rd_u : r_rd_l;
    end

    // Work vector write ports.
    always_comb begin
        we_a    = 1'b0;
        we_b    = 1'b0;
        waddr_a = vaddr;
        wdata_a = q;
        wdata_b = q;
        case (i_cmd.op)
            OP_VEC_WRITE: begin
                we_a = !i_cmd.dst_b;
                we_b = i_cmd.dst_b;
            end
            OP_PRM_WRITE: begin
                we_b    = 1'b1;
                wdata_b = p_ok ? r_rd_r : 32'd0;
            end
            OP_CLEAR: begin
                we_a    = 1'b1;
                wdata_a = '0;
            end
            OP_SCATTER: begin
                we_a    = p_ok;
                waddr_a = paddr;
                wdata_a = r_rd_b;
            end
            default: begin
                we_a = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[waddr_a] <= wdata_a;
        end
        if (we_b) begin
            r_mem_b[vaddr] <= wdata_b;
        end
        r_rd_a <= r_mem_a[vaddr];
        r_rd_b <= r_mem_b[vaddr];
    end

    // Full 64-bit signed product of coefficient and vector element.
    assign prod = $signed(coef) * $signed(dst_val);

    // Accumulator with saturating subtract of the registered product.
    assign diff = {r_acc[63], r_acc} - {r_prod[63], r_prod};

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACC_INIT: r_acc <= {{32{src_val[31]}}, src_val} << FRAC_BITS;
            OP_MUL:      r_prod <= prod;
            OP_ACC_SUB: begin
                if (diff[64] != diff[63]) begin
                    r_acc <= diff[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                end else begin
                    r_acc <= diff[63:0];
                end
            end
            default: r_acc <= r_acc;
        endcase
    end

    lts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_START),
        .i_dividend (r_acc),
        .i_divisor  (coef),
        .o_done     (div_done),
        .o_quotient (q),
        .o_div_zero (div_zero)
    );

    // Sticky zero-diagonal flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (i_cmd.op == OP_VEC_WRITE && div_zero) begin
            r_err <= 1'b1;
        end
    end

    // Output register for one result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.op == OP_OUT) begin
            r_oindex <= i_cmd.vaddr[3:0];
            r_osol   <= i_cmd.out_b ? r_rd_b : r_rd_a;
            r_oerr   <= r_err;
            r_oend   <= i_cmd.out_last;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.index      = r_oindex;
    assign o_out.solution   = r_osol;
    assign o_out.div_error  = r_oerr;
    assign o_out.end_of_run = r_oend;

    assign o_stat.solve_req = (i_kind == KIND_RHS) && i_last && row_ok;
    assign o_stat.out_free  = !r_ovalid || o_out.ready;
    assign o_stat.div_done  = div_done;
endmodule
`default_nettype wire

FILE: rtl/lts_ctrl.sv
`default_nettype none
module lts_ctrl #(
    parameter int MAX_ORDER = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lts_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [lts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire lts_pkg::t_stat                  i_stat,
    output lts_pkg::t_cmd                        o_cmd
);
    import lts_pkg::*;

    localparam int CW = $clog2(MAX_ORDER + 1);

    typedef enum logic [17:0] {
        S_LOAD    = 18'h00001,
        S_PRM_RD  = 18'h00002,
        S_PRM_RR  = 18'h00004,
        S_PRM_WR  = 18'h00008,
        S_ROW_RD  = 18'h00010,
        S_ROW_INI = 18'h00020,
        S_TERM    = 18'h00040,
        S_MUL     = 18'h00080,
        S_ACC     = 18'h00100,
        S_DIAG_WT = 18'h00200,
        S_DIV_WT  = 18'h00400,
        S_CLR     = 18'h00800,
        S_SC_RD   = 18'h01000,
        S_SC_WR   = 18'h02000,
        S_OUT_RD  = 18'h04000,
        S_OUT_LD  = 18'h08000,
        S_DIV     = 18'h10000,
        S_SPARE   = 18'h20000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_n, n_n;
    logic          r_bwd, n_bwd;
    logic [4:0]    r_order;
    logic          r_tr;
    logic [CW-1:0] n_eff;
    logic          fwd, row_last, cnt_last, term_go;
    logic [CW-1:0] col_sel;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 5'd16;
            r_tr    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORDER: r_order <= i_cfg_data;
                CFG_TRANS: r_tr    <= i_cfg_data[0];
                default:   r_tr    <= r_tr;
            endcase
        end
    end

    // Order clamped to the range of the stores.
    always_comb begin
        if (r_order == 5'd0) begin
            n_eff = CW'(1);
        end else if (32'(r_order) > MAX_ORDER) begin
            n_eff = CW'(MAX_ORDER);
        end else begin
            n_eff = CW'(r_order);
        end
    end

    assign fwd      = !r_bwd;
    assign cnt_last = (r_i == r_n - CW'(1));
    assign row_last = fwd ? cnt_last : (r_i == '0);
    assign term_go  = fwd ? (r_j < r_i) : (r_j < r_n);
    assign col_sel  = (r_state == S_TERM && term_go) ? r_j : r_i;

    // Command fields that follow from the counters and the pass.
    always_comb begin
        o_cmd.op          = OP_NONE;
        o_cmd.vaddr       = IDX_MAX_W'(r_i);
        o_cmd.mrow        = IDX_MAX_W'(r_tr ? col_sel : r_i);
        o_cmd.mcol        = IDX_MAX_W'(r_tr ? r_i : col_sel);
        o_cmd.mat_u       = r_bwd ^ r_tr;
        o_cmd.src_sel     = r_bwd ? SRC_A : (r_tr ? SRC_R : SRC_B);
        o_cmd.dst_b       = r_bwd;
        o_cmd.out_b       = !r_tr;
        o_cmd.rhs_by_perm = (r_state == S_PRM_RR) || (r_state == S_PRM_WR);
        o_cmd.n           = CNT_MAX_W'(r_n);
        o_cmd.out_last    = cnt_last;
        if (r_state == S_TERM && term_go) begin
            o_cmd.vaddr = IDX_MAX_W'(r_j);
        end
        case (r_state)
            S_LOAD:    o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_PRM_WR:  o_cmd.op = OP_PRM_WRITE;
            S_ROW_INI: o_cmd.op = OP_ACC_INIT;
            S_MUL:     o_cmd.op = OP_MUL;
            S_ACC:     o_cmd.op = OP_ACC_SUB;
            S_DIAG_WT: o_cmd.op = OP_DIV_START;
            S_DIV_WT:  o_cmd.op = i_stat.div_done ? OP_VEC_WRITE : OP_NONE;
            S_CLR:     o_cmd.op = OP_CLEAR;
            S_SC_WR:   o_cmd.op = OP_SCATTER;
            S_OUT_LD:  o_cmd.op = i_stat.out_free ? OP_OUT : OP_NONE;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_ready = (r_state == S_LOAD);

    // Sequencer over plain-mode permute, two substitution passes, transpose-mode unpermute and output.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_n     = r_n;
        n_bwd   = r_bwd;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid && i_stat.solve_req) begin
                    n_n     = n_eff;
                    n_i     = '0;
                    n_bwd   = 1'b0;
                    n_state = r_tr ? S_ROW_RD : S_PRM_RD;
                end
            end
            S_PRM_RD: n_state = S_PRM_RR;
            S_PRM_RR: n_state = S_PRM_WR;
            S_PRM_WR: begin
                if (cnt_last) begin
                    n_i     = '0;
                    n_state = S_ROW_RD;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_PRM_RD;
                end
            end
            S_ROW_RD: n_state = S_ROW_INI;
            S_ROW_INI: begin
                n_j     = fwd ? '0 : (r_i + CW'(1));
                n_state = S_TERM;
            end
            S_TERM:    n_state = term_go ? S_MUL : S_DIAG_WT;
            S_MUL:     n_state = S_ACC;
            S_ACC: begin
                n_j     = r_j + CW'(1);
                n_state = S_TERM;
            end
            S_DIAG_WT: n_state = S_DIV;
            S_DIV:     n_state = S_DIV_WT;
            S_DIV_WT: begin
                if (i_stat.div_done) begin
                    if (!row_last) begin
                        n_i     = fwd ? (r_i + CW'(1)) : (r_i - CW'(1));
                        n_state = S_ROW_RD;
                    end else if (fwd) begin
                        n_bwd   = 1'b1;
                        n_i     = r_n - CW'(1);
                        n_state = S_ROW_RD;
                    end else begin
                        n_i     = '0;
                        n_state = r_tr ? S_CLR : S_OUT_RD;
                    end
                end
            end
            S_CLR: begin
                if (cnt_last) begin
                    n_i     = '0;
                    n_state = S_SC_RD;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_SC_RD: n_state = S_SC_WR;
            S_SC_WR: begin
                if (cnt_last) begin
                    n_i     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_SC_RD;
                end
            end
            S_OUT_RD: n_state = S_OUT_LD;
            S_OUT_LD: begin
                if (i_stat.out_free) begin
                    if (cnt_last) begin
                        n_state = S_LOAD;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_i     <= '0;
            r_j     <= '0;
            r_n     <= CW'(1);
            r_bwd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_n     <= n_n;
            r_bwd   <= n_bwd;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lu_triangular_solver_top.sv
// Channel  | Role   | Payload
// i_in     | sink   | kind, row, col, value, last
// o_out    | source | index, solution, div_error, end_of_run
// i_cfg_*  | write  | order_in_use (index 0), transpose_mode (index 1)
//
// Load beats are taken one per cycle. A last rhs beat starts a solve, during
// which i_in.ready is low: permute or unpermute steps through the elements, and
// each row of a pass multiplies and subtracts its off-diagonal terms, then divides
// on the shared bit-serial 64-by-32 divider. Results leave through an output
// register, each loaded once the last is taken, and stall freely on o_out.ready.
// Reset is synchronous and active low; stores hold no reset value.
`default_nettype none
module lu_triangular_solver_top #(
    parameter int MAX_ORDER = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lts_in_if.sink                              i_in,
    lts_out_if.source                           o_out
);
    import lts_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    lts_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lts_datapath #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_kind     (i_in.kind),
        .i_row      (i_in.row),
        .i_col      (i_in.col),
        .i_value    (i_in.value),
        .i_last     (i_in.last),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out      (o_out)
    );

    assign i_in.ready = in_ready;
endmodule
`default_nettype wire

FILE: rtl/lts_checker.sv
`default_nettype none
module lts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_solution,
    input wire logic        i_div_error,
    input wire logic        i_end_of_run
);
    // A stalled result beat holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_solution))
        else $error("stalled result beat changed");

    // Loading is closed while a run still has beats to deliver.
    a_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_end_of_run |-> !i_in_ready)
        else $error("input open in the middle of a run");

    // The error flag never falls once a beat has carried it.
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_valid && i_out_ready && i_div_error) && i_out_valid |-> i_div_error)
        else $error("error flag dropped");

    // Nothing is offered right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat after reset");

    logic unused_in_valid;
    assign unused_in_valid = i_in_valid;
endmodule

bind lu_triangular_solver_top lts_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_solution   (o_out.solution),
    .i_div_error  (o_out.div_error),
    .i_end_of_run (o_out.end_of_run)
);
`default_nettype wire
